// File: hw/rtl/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg: shared types, constants and decode helpers
// Item and result structs, the front-to-back operation format and the
// base-16 pair decode used by the back end.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [4:0] HEX_NONE     = 5'd16;

  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_string;
  } out_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  typedef enum logic {
    OP_PLAIN = 1'b0,
    OP_PAIR  = 1'b1
  } op_kind_t;

  // One classified operation handed from front to back
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] a;
    logic [7:0] b;
    logic       last;
  } op_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  // Hex digit value, HEX_NONE when not a digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if (c inside {[8'h30:8'h39]}) v = {1'b0, c[3:0]};
    else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) v = 5'(c[3:0] + 4'd9);
    return v;
  endfunction

  // Base-16 parse of a two-character string, cut to 8 bits
  function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] va;
    logic [4:0] vb;
    logic       vb_ok;
    logic [7:0] res;
    va    = hex_val(a);
    vb    = hex_val(b);
    vb_ok = (vb != HEX_NONE);
    res   = 8'h00;
    if (is_ws(a) || (a == CHAR_PLUS)) begin
      res = vb_ok ? {4'h0, vb[3:0]} : 8'h00;
    end else if (a == CHAR_MINUS) begin
      res = vb_ok ? 8'(8'h00 - {4'h0, vb[3:0]}) : 8'h00;
    end else if (va != HEX_NONE) begin
      res = vb_ok ? {va[3:0], vb[3:0]} : {4'h0, va[3:0]};
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/upd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_fifo: small operation queue
// Register-based FIFO between the classifying front and the decoding back;
// head entry is shown combinationally.
// ----------------------------------------------------------------------------
module upd_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CntFull);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store incoming entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

// File: hw/rtl/upd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front: byte classifier
// Tracks the escape phase, collects escape digits and emits one plain or
// pair operation for each byte that completes a character or ends a string.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  upd_pkg::in_t  item,
  output logic          op_valid,
  output upd_pkg::op_t  op
);

  import upd_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] first_char;

  // Next escape phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (item.last) begin
        phase_next = PH_IDLE;
      end else begin
        case (phase)
          PH_FIRST:  phase_next = PH_SECOND;
          PH_SECOND: phase_next = PH_IDLE;
          default:   phase_next = (item.in_byte == CHAR_PERCENT) ? PH_FIRST : PH_IDLE;
        endcase
      end
    end
  end

  // Build the operation for this byte
  always_comb begin
    op_valid = 1'b0;
    op.kind  = OP_PAIR;
    op.a     = CHAR_NUL;
    op.b     = CHAR_NUL;
    op.last  = item.last;
    case (phase)
      PH_FIRST: begin
        op_valid = accept && item.last;
        op.a     = item.in_byte;
      end
      PH_SECOND: begin
        op_valid = accept;
        op.a     = first_char;
        op.b     = item.in_byte;
      end
      default: begin
        if (item.in_byte == CHAR_PERCENT) begin
          op_valid = accept && item.last;
        end else begin
          op_valid = accept;
          op.kind  = OP_PLAIN;
          op.a     = (item.in_byte == CHAR_PLUS) ? CHAR_SPACE : item.in_byte;
        end
      end
    endcase
  end

  // Hold phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Capture first escape digit
  always_ff @(posedge clk) begin
    if (accept && (phase == PH_FIRST)) begin
      first_char <= item.in_byte;
    end
  end

endmodule

// File: hw/rtl/upd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back: decoder and result register
// Decodes queued operations, drops characters after a decoded NUL and
// holds one result for the consumer.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  input  upd_pkg::op_t  op,
  output logic          op_pop,
  output upd_pkg::out_t result,
  output logic          empty,
  input  logic          pop
);

  import upd_pkg::*;

  logic       out_valid;
  logic       string_ended;
  logic [7:0] value;
  logic       value_zero;
  logic       emit;
  logic       keep;

  // Decode the head operation
  assign value      = (op.kind == OP_PLAIN) ? op.a : decode_pair(op.a, op.b);
  assign value_zero = (value == CHAR_NUL);
  assign keep       = !string_ended && !value_zero;
  assign op_pop     = op_valid && (!out_valid || pop);
  assign emit       = op_pop && (op.last || keep);
  assign empty      = !out_valid;

  // Track result register and end-of-string state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      string_ended <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (op_pop) begin
        if (op.last) string_ended <= 1'b0;
        else if (value_zero) string_ended <= 1'b1;
      end
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      result.out_byte      <= keep ? value : CHAR_NUL;
      result.has_byte      <= keep;
      result.end_of_string <= op.last;
    end
  end

endmodule

// File: hw/rtl/url_percent_decoder_core.sv
`timescale 1ns / 1ps
// Path: the byte that completes a result is registered in the queue, then
//   decoded into the result register, where it becomes visible.
// Throughput: one byte per cycle; a stalled consumer fills the queue, then full rises.
// Reset: synchronous, active high; clears escape phase, queue and result register.
// ----------------------------------------------------------------------------
// url_percent_decoder_core: URL percent decoder
// Front classifies bytes into operations, a short queue decouples it from
// the back end that decodes escapes and drives the result queue interface.
// ----------------------------------------------------------------------------
module url_percent_decoder_core #(
  parameter int QUEUE_DEPTH = upd_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  upd_pkg::in_t  item,
  output logic          empty,
  input  logic          pop,
  output upd_pkg::out_t result
);

  import upd_pkg::*;

  localparam int OpW = $bits(op_t);

  logic           accept;
  logic           front_valid;
  op_t            front_op;
  logic [OpW-1:0] q_data;
  logic           q_empty;
  logic           q_pop;

  assign accept = push && !full;

  // Classify incoming bytes
  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .op_valid (front_valid),
    .op       (front_op)
  );

  // Decouple front and back
  upd_fifo #(
    .WIDTH (OpW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_op),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  // Decode and present results
  upd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (!q_empty),
    .op       (op_t'(q_data)),
    .op_pop   (q_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

`ifndef NO_ASSERTIONS
  a_byte_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.has_byte) |-> (result.out_byte != 8'h00))
    else $error("decoded byte flagged present but zero");

  a_mid_has_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.end_of_string) |-> result.has_byte)
    else $error("result without byte before end of string");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result pending right after reset");
`endif

endmodule
